>>> rtl/rmbd_pkg.sv
// rmbd_pkg: shared types and constants for the mipmap box downsampler.
// No dependencies.
`default_nettype none
package rmbd_pkg;

  localparam int unsigned MAX_LEVELS_DEF = 10;
  localparam int unsigned FIFO_DEPTH     = 4;
  localparam int unsigned CFG_IDX_W      = 2;
  localparam int unsigned CFG_DATA_W     = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_LOG2_IMAGE_SIZE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOG2_MIN_SIZE   = 2'd1;

  localparam logic [3:0] LOG2_IMAGE_SIZE_RST = 4'd10;
  localparam logic [3:0] LOG2_MIN_SIZE_RST   = 4'd0;

  typedef struct packed {
    logic [7:0] b;
    logic [7:0] g;
    logic [7:0] r;
  } pix_t;

  typedef struct packed {
    logic [3:0] level;
    pix_t       pix;
    logic       last;
  } res_t;

endpackage
`default_nettype wire

>>> rtl/rmbd_front.sv
// rmbd_front: accepts input pixels, drops them when no level is built,
// and queues the rest for the level engine. Uses rmbd_pkg.
`default_nettype none
module rmbd_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire rmbd_pkg::pix_t in_pix_i,
  input  wire logic [3:0]    nlev_i,
  output logic               q_valid_o,
  output rmbd_pkg::pix_t     q_pix_o,
  input  wire logic          q_pop_i
);
  import rmbd_pkg::*;

  localparam int unsigned PW = $clog2(FIFO_DEPTH);

  pix_t            mem_q [FIFO_DEPTH];
  logic [PW-1:0]   head_q, tail_q;
  logic [PW:0]     cnt_q;
  logic            push, pop;

  assign in_stall_o = (cnt_q == (PW+1)'(FIFO_DEPTH));
  assign push       = in_valid_i && !in_stall_o && (nlev_i != 4'd0);
  assign pop        = q_pop_i && q_valid_o;
  assign q_valid_o  = (cnt_q != '0);
  assign q_pix_o    = mem_q[head_q];

  always_ff @(posedge clk_i) begin
    if (push) mem_q[tail_q] <= in_pix_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push) tail_q <= tail_q + PW'(1);
      if (pop)  head_q <= head_q + PW'(1);
      if (push && !pop)      cnt_q <= cnt_q + (PW+1)'(1);
      else if (pop && !push) cnt_q <= cnt_q - (PW+1)'(1);
    end
  end
endmodule
`default_nettype wire

>>> rtl/rmbd_back.sv
// rmbd_back: level engine; one level step per cycle unless a stalled result blocks it,
// row pair sum memory, per-level hold and raster position, output register. Uses rmbd_pkg.
`default_nettype none
module rmbd_back #(
  parameter int unsigned MAX_LEVELS = rmbd_pkg::MAX_LEVELS_DEF
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic [3:0]    lg_i,
  input  wire logic [3:0]    nlev_i,
  input  wire logic          cfg_clr_i,
  input  wire logic          q_valid_i,
  input  wire rmbd_pkg::pix_t q_pix_i,
  output logic               q_pop_o,
  output logic               busy_o,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output rmbd_pkg::res_t     out_res_o
);
  import rmbd_pkg::*;

  localparam int unsigned AW   = MAX_LEVELS;
  localparam int unsigned SW   = MAX_LEVELS + 1;
  localparam int unsigned SIDE = 1 << AW;
  localparam int unsigned LVW  = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;

  logic [29:0]    sums_mem [SIDE];
  logic [29:0]    rd_q;
  pix_t           hold_q [MAX_LEVELS];
  logic [AW-1:0]  pos_x_q [MAX_LEVELS];
  logic [AW-1:0]  pos_y_q [MAX_LEVELS];
  logic [LVW-1:0] lev_q, lev_d;
  pix_t           pix_q, pix_d;
  logic           busy_q, busy_d;
  logic           out_valid_q;
  res_t           out_q;

  logic [LVW-1:0] k;
  logic [AW-1:0]  x, y, nx, ny, rd_x;
  logic [3:0]     shift, shift_d;
  logic [SW-1:0]  side_m1, base, base_d;
  logic           x_last, y_last, out_case, cont_ok, cont, step, done, take;
  logic [4:0]     kp1;
  logic [MAX_LEVELS:0] oo, oo_sh;
  logic [9:0]     p_r, p_g, p_b, s_r, s_g, s_b;
  logic [10:0]    t_r, t_g, t_b;
  logic [AW-1:0]  wa, ra;
  pix_t           avg;
  pix_t           h;

  always_comb begin
    for (int i = 0; i < MAX_LEVELS; i++) oo[i] = pos_x_q[i][0] & pos_y_q[i][0];
    oo[MAX_LEVELS] = 1'b0;
  end

  assign k       = lev_q;
  assign x       = pos_x_q[k];
  assign y       = pos_y_q[k];
  assign h       = hold_q[k];
  assign shift   = lg_i - 4'(k);
  assign side_m1 = (SW'(1) << shift) - SW'(1);
  assign base    = (SW'(1) << lg_i) - (SW'(1) << shift);
  assign x_last  = ({1'b0, x} == side_m1);
  assign y_last  = ({1'b0, y} == side_m1);
  assign nx      = x_last ? '0 : x + AW'(1);
  assign ny      = x_last ? (y_last ? '0 : y + AW'(1)) : y;

  assign p_r = {2'b0, pix_q.r} + {2'b0, h.r};
  assign p_g = {2'b0, pix_q.g} + {2'b0, h.g};
  assign p_b = {2'b0, pix_q.b} + {2'b0, h.b};
  assign s_r = p_r + rd_q[9:0];
  assign s_g = p_g + rd_q[19:10];
  assign s_b = p_b + rd_q[29:20];
  assign t_r = {1'b0, s_r} + 11'd2;
  assign t_g = {1'b0, s_g} + 11'd2;
  assign t_b = {1'b0, s_b} + 11'd2;
  assign avg = '{b: t_b[9:2], g: t_g[9:2], r: t_r[9:2]};

  assign kp1      = 5'(k) + 5'd1;
  assign oo_sh    = oo >> kp1;
  assign out_case = x[0] && y[0];
  assign cont_ok  = kp1 < {1'b0, nlev_i};
  assign cont     = out_case && cont_ok;
  assign step     = busy_q && !(out_case && out_valid_q && out_stall_i);
  assign done     = step && !cont;
  assign take     = q_valid_i && (!busy_q || done);
  assign q_pop_o  = take;
  assign busy_o   = busy_q;

  always_comb begin
    lev_d  = lev_q;
    pix_d  = pix_q;
    busy_d = busy_q;
    if (take) begin
      lev_d  = '0;
      pix_d  = q_pix_i;
      busy_d = 1'b1;
    end else if (step && cont) begin
      lev_d = LVW'(kp1);
      pix_d = avg;
    end else if (done) begin
      busy_d = 1'b0;
    end
  end

  // read ahead for the level handled next cycle
  assign rd_x    = (step && (lev_d == k)) ? nx : pos_x_q[lev_d];
  assign shift_d = lg_i - 4'(lev_d);
  assign base_d  = (SW'(1) << lg_i) - (SW'(1) << shift_d);
  assign ra      = AW'(base_d) + (rd_x >> 1);
  assign wa      = AW'(base) + (x >> 1);

  always_ff @(posedge clk_i) begin
    if (step && x[0] && !y[0]) sums_mem[wa] <= {p_b, p_g, p_r};
    rd_q <= sums_mem[ra];
    if (step && !x[0]) hold_q[k] <= pix_q;
    pix_q <= pix_d;
    if (step && out_case) begin
      out_q.level <= 4'(kp1);
      out_q.pix   <= avg;
      out_q.last  <= !cont_ok || !oo_sh[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lev_q       <= '0;
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < MAX_LEVELS; i++) begin
        pos_x_q[i] <= '0;
        pos_y_q[i] <= '0;
      end
    end else begin
      lev_q  <= lev_d;
      busy_q <= busy_d;
      if (step && out_case) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
      if (cfg_clr_i) begin
        for (int i = 0; i < MAX_LEVELS; i++) begin
          pos_x_q[i] <= '0;
          pos_y_q[i] <= '0;
        end
      end else if (step) begin
        pos_x_q[k] <= nx;
        pos_y_q[k] <= ny;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;
endmodule
`default_nettype wire

>>> rtl/rgb_mipmap_box_downsampler_unit.sv
// rgb_mipmap_box_downsampler_unit: top level, config registers, front queue
// and level engine. Uses rmbd_pkg, rmbd_front, rmbd_back.
//
//  channel | signals                                   | direction
//  in      | in_valid_i/in_stall_o, red/green/blue     | beat in
//  out     | out_valid_o/out_stall_i, level, rgb, last | beat out
//  cfg     | cfg_we_i, cfg_idx_i, cfg_data_i           | write only
//
// An input beat is taken every cycle into a four-deep queue while it is not
// full. The engine works a pixel through one level at a time, from 1 up to
// nlev levels, about 4/3 on average; it takes the next pixel in its last step.
// Reset clears positions and control; sum and hold stores are not cleared.
// A stalled output blocks only the engine step that produces a result.
`default_nettype none
module rgb_mipmap_box_downsampler_unit #(
  parameter int unsigned MAX_LEVELS = rmbd_pkg::MAX_LEVELS_DEF
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] red_i,
  input  wire logic [7:0] green_i,
  input  wire logic [7:0] blue_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [3:0]      level_o,
  output logic [7:0]      out_red_o,
  output logic [7:0]      out_green_o,
  output logic [7:0]      out_blue_o,
  output logic            last_of_run_o,
  input  wire logic       cfg_we_i,
  input  wire logic [rmbd_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [rmbd_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import rmbd_pkg::*;

  logic [3:0] lg_q, min_q, lg, nlev;
  logic       cfg_clr, q_valid, q_pop, busy;
  pix_t       in_pix, q_pix;
  res_t       res;

  assign cfg_clr = cfg_we_i &&
                   (cfg_idx_i == CFG_LOG2_IMAGE_SIZE || cfg_idx_i == CFG_LOG2_MIN_SIZE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lg_q  <= LOG2_IMAGE_SIZE_RST;
      min_q <= LOG2_MIN_SIZE_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_LOG2_IMAGE_SIZE: lg_q  <= cfg_data_i;
        CFG_LOG2_MIN_SIZE:   min_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign lg     = (lg_q > 4'(MAX_LEVELS)) ? 4'(MAX_LEVELS) : lg_q;
  assign nlev   = (lg > min_q) ? lg - min_q : 4'd0;
  assign in_pix = '{b: blue_i, g: green_i, r: red_i};

  rmbd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_pix_i   (in_pix),
    .nlev_i     (nlev),
    .q_valid_o  (q_valid),
    .q_pix_o    (q_pix),
    .q_pop_i    (q_pop)
  );

  rmbd_back #(.MAX_LEVELS(MAX_LEVELS)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .lg_i        (lg),
    .nlev_i      (nlev),
    .cfg_clr_i   (cfg_clr),
    .q_valid_i   (q_valid),
    .q_pix_i     (q_pix),
    .q_pop_o     (q_pop),
    .busy_o      (busy),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_res_o   (res)
  );

  assign level_o       = res.level;
  assign out_red_o     = res.pix.r;
  assign out_green_o   = res.pix.g;
  assign out_blue_o    = res.pix.b;
  assign last_of_run_o = res.last;

  a_level_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (level_o != 4'd0) && (level_o <= 4'(MAX_LEVELS)))
    else $error("result level out of range");

  a_pop_needs_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid)
    else $error("engine took from an empty queue");

  a_idle_on_cfg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_clr |-> !busy && !q_valid)
    else $error("configuration written while busy");
endmodule
`default_nettype wire
